/* rtl/core/ppc_relocation_patch_core_assert.svh */
// Assertion macros shared by the relocation patch core.
// No dependencies; included by files that carry concurrent checks.
`ifndef PPC_RELOCATION_PATCH_CORE_ASSERT_SVH
`define PPC_RELOCATION_PATCH_CORE_ASSERT_SVH

// Checked at every rising edge of clk, masked while rst is high.
`define PPCREL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define PPCREL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/ppcrel_pkg.sv */
// Types, relocation codes, masks and the type decoder for the relocation core.
// No dependencies.
package ppcrel_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 8;
  localparam int unsigned HalfW = 16;

  // Relocation type numbers handled by the core
  localparam logic [KindW-1:0] R_ADDR32          = 8'd1;
  localparam logic [KindW-1:0] R_ADDR24          = 8'd2;
  localparam logic [KindW-1:0] R_ADDR16          = 8'd3;
  localparam logic [KindW-1:0] R_ADDR16_LO       = 8'd4;
  localparam logic [KindW-1:0] R_ADDR16_HI       = 8'd5;
  localparam logic [KindW-1:0] R_ADDR16_HA       = 8'd6;
  localparam logic [KindW-1:0] R_ADDR14          = 8'd7;
  localparam logic [KindW-1:0] R_ADDR14_BRTAKEN  = 8'd8;
  localparam logic [KindW-1:0] R_ADDR14_BRNTAKEN = 8'd9;
  localparam logic [KindW-1:0] R_REL24           = 8'd10;
  localparam logic [KindW-1:0] R_REL14           = 8'd11;
  localparam logic [KindW-1:0] R_REL14_BRTAKEN   = 8'd12;
  localparam logic [KindW-1:0] R_REL14_BRNTAKEN  = 8'd13;
  localparam logic [KindW-1:0] R_PLTREL24        = 8'd18;
  localparam logic [KindW-1:0] R_LOCAL24PC       = 8'd23;
  localparam logic [KindW-1:0] R_UADDR32         = 8'd24;
  localparam logic [KindW-1:0] R_UADDR16         = 8'd25;
  localparam logic [KindW-1:0] R_REL32           = 8'd26;
  localparam logic [KindW-1:0] R_SECTOFF         = 8'd33;
  localparam logic [KindW-1:0] R_SECTOFF_LO      = 8'd34;
  localparam logic [KindW-1:0] R_SECTOFF_HI      = 8'd35;
  localparam logic [KindW-1:0] R_SECTOFF_HA      = 8'd36;
  localparam logic [KindW-1:0] R_ADDR30          = 8'd37;
  localparam logic [KindW-1:0] R_NADDR32         = 8'd101;
  localparam logic [KindW-1:0] R_NADDR16         = 8'd102;
  localparam logic [KindW-1:0] R_NADDR16_LO      = 8'd103;
  localparam logic [KindW-1:0] R_NADDR16_HI      = 8'd104;
  localparam logic [KindW-1:0] R_NADDR16_HA      = 8'd105;

  // Keep, insert and hint masks of the field forms
  localparam logic [WordW-1:0] F24_KEEP  = 32'hfc000003;
  localparam logic [WordW-1:0] F24_INS   = 32'h03fffffc;
  localparam logic [WordW-1:0] F14_KEEP  = 32'hffff0003;
  localparam logic [WordW-1:0] F14_INS   = 32'h0000fffc;
  localparam logic [WordW-1:0] F14H_KEEP = 32'hffdf0003;
  localparam logic [WordW-1:0] F14_HINT  = 32'h00200000;
  localparam logic [WordW-1:0] W30_KEEP  = 32'h00000003;
  localparam logic [WordW-1:0] W30_INS   = 32'hfffffffc;

  typedef enum logic [1:0] {
    RULE_ABS, RULE_REL, RULE_SECT, RULE_NEG
  } rule_t;

  typedef enum logic [3:0] {
    FORM_NONE, FORM_W32, FORM_F24, FORM_F14, FORM_F14T, FORM_F14N, FORM_W30,
    FORM_HALF, FORM_HI, FORM_HA
  } form_t;

  typedef struct packed {
    rule_t rule;
    form_t form;
  } class_t;

  // Stage 2 contents handed to the merge stage
  typedef struct packed {
    form_t             form;
    logic [WordW-1:0]  value;
    logic [WordW-1:0]  target;
    logic [WordW-1:0]  old_word;
  } merge_t;

  function automatic class_t classify(input logic [KindW-1:0] kind);
    class_t c;
    c.rule = RULE_ABS;
    c.form = FORM_NONE;
    case (kind)
      R_ADDR32:          c = '{RULE_ABS,  FORM_W32};
      R_ADDR24:          c = '{RULE_ABS,  FORM_F24};
      R_ADDR16:          c = '{RULE_ABS,  FORM_HALF};
      R_ADDR16_LO:       c = '{RULE_ABS,  FORM_HALF};
      R_ADDR16_HI:       c = '{RULE_ABS,  FORM_HI};
      R_ADDR16_HA:       c = '{RULE_ABS,  FORM_HA};
      R_ADDR14:          c = '{RULE_ABS,  FORM_F14};
      R_ADDR14_BRTAKEN:  c = '{RULE_ABS,  FORM_F14T};
      R_ADDR14_BRNTAKEN: c = '{RULE_ABS,  FORM_F14N};
      R_REL24:           c = '{RULE_REL,  FORM_F24};
      R_REL14:           c = '{RULE_REL,  FORM_F14};
      R_REL14_BRTAKEN:   c = '{RULE_REL,  FORM_F14T};
      R_REL14_BRNTAKEN:  c = '{RULE_REL,  FORM_F14N};
      R_PLTREL24:        c = '{RULE_REL,  FORM_F24};
      R_LOCAL24PC:       c = '{RULE_REL,  FORM_F24};
      R_UADDR32:         c = '{RULE_ABS,  FORM_W32};
      R_UADDR16:         c = '{RULE_ABS,  FORM_HALF};
      R_REL32:           c = '{RULE_REL,  FORM_W32};
      R_SECTOFF:         c = '{RULE_SECT, FORM_W32};
      R_SECTOFF_LO:      c = '{RULE_SECT, FORM_HALF};
      R_SECTOFF_HI:      c = '{RULE_SECT, FORM_HI};
      R_SECTOFF_HA:      c = '{RULE_SECT, FORM_HA};
      R_ADDR30:          c = '{RULE_REL,  FORM_W30};
      R_NADDR32:         c = '{RULE_NEG,  FORM_W32};
      R_NADDR16:         c = '{RULE_NEG,  FORM_HALF};
      R_NADDR16_LO:      c = '{RULE_NEG,  FORM_HALF};
      R_NADDR16_HI:      c = '{RULE_NEG,  FORM_HI};
      R_NADDR16_HA:      c = '{RULE_NEG,  FORM_HA};
      default:           c = '{RULE_ABS,  FORM_NONE};
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/ppcrel_in_if.sv */
// Relocation request channel: valid/ready plus one relocation entry.
// Depends on ppcrel_pkg.
interface ppcrel_in_if;
  logic                                valid;
  logic                                ready;
  logic [ppcrel_pkg::KindW-1:0]        kind;
  logic [ppcrel_pkg::WordW-1:0]        offset;
  logic signed [ppcrel_pkg::WordW-1:0] addend;
  logic [ppcrel_pkg::WordW-1:0]        base_address;
  logic [ppcrel_pkg::WordW-1:0]        symbol_address;
  logic [ppcrel_pkg::WordW-1:0]        old_word;

  modport source (
    output valid, kind, offset, addend, base_address, symbol_address, old_word,
    input  ready
  );
  modport sink (
    input  valid, kind, offset, addend, base_address, symbol_address, old_word,
    output ready
  );
endinterface

/* rtl/core/ppcrel_out_if.sv */
// Patch result channel: valid/ready plus target address and patch data.
// Depends on ppcrel_pkg.
interface ppcrel_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppcrel_pkg::WordW-1:0] target_address;
  logic [ppcrel_pkg::WordW-1:0] patch_value;
  logic                         halfword_write;
  logic                         unsupported;

  modport source (
    output valid, target_address, patch_value, halfword_write, unsupported,
    input  ready
  );
  modport sink (
    input  valid, target_address, patch_value, halfword_write, unsupported,
    output ready
  );
endinterface

/* rtl/core/ppc_relocation_patch_core.sv */
// Top level of the PowerPC ELF32 relocation patch core: decode/add, value and merge stages.
// Depends on ppcrel_pkg, ppcrel_in_if, ppcrel_out_if and ppcrel_merge.
//
//   channel  dir  carries
//   reloc    in   kind, offset, addend, base_address, symbol_address, old_word
//   patch    out  target_address, patch_value, halfword_write, unsupported
//
// Three register stages (decode and sums, value select, merge).
// One relocation per cycle sustained while patch does not stall; the 32-bit adders in stages 1 and 2 set the pace.
// rst is synchronous and clears the stage valid bits only.
// A stall on patch holds every occupied stage; empty stages still fill behind it.
module ppc_relocation_patch_core (
  input  logic        clk,
  input  logic        rst,
  ppcrel_in_if.sink   reloc,
  ppcrel_out_if.source patch
);
  import ppcrel_pkg::*;

  class_t           cls;
  logic             s1_valid;
  rule_t            s1_rule;
  form_t            s1_form;
  logic [WordW-1:0] s1_target;
  logic [WordW-1:0] s1_sym_add;
  logic [WordW-1:0] s1_off_add;
  logic [WordW-1:0] s1_add_sym;
  logic [WordW-1:0] s1_old;
  logic             s2_valid;
  merge_t           s2;
  logic [WordW-1:0] value_next;
  logic             adv_s1;
  logic             adv_s2;
  logic             merge_ready;

  assign cls    = classify(reloc.kind);
  assign adv_s2 = !s2_valid || merge_ready;
  assign adv_s1 = !s1_valid || adv_s2;
  assign reloc.ready = adv_s1;

  // stage 1: decode, target address and the three operand sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_s1) begin
      s1_valid <= reloc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1 && reloc.valid) begin
      s1_rule    <= cls.rule;
      s1_form    <= cls.form;
      s1_target  <= reloc.base_address + reloc.offset;
      s1_sym_add <= reloc.symbol_address + reloc.addend;
      s1_off_add <= reloc.offset + reloc.addend;
      s1_add_sym <= reloc.addend - reloc.symbol_address;
      s1_old     <= reloc.old_word;
    end
  end

  // stage 2: value by rule; PC-relative subtracts the target
  always_comb begin
    case (s1_rule)
      RULE_ABS:  value_next = s1_sym_add;
      RULE_REL:  value_next = s1_sym_add - s1_target;
      RULE_SECT: value_next = s1_off_add;
      RULE_NEG:  value_next = s1_add_sym;
      default:   value_next = s1_sym_add;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv_s2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s2 && s1_valid) begin
      s2.form     <= s1_form;
      s2.value    <= value_next;
      s2.target   <= s1_target;
      s2.old_word <= s1_old;
    end
  end

  ppcrel_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .valid (s2_valid),
    .stage (s2),
    .ready (merge_ready),
    .patch (patch)
  );

endmodule

/* rtl/core/ppcrel_merge.sv */
// Final stage: merges the relocation value into the old word and holds the result.
// Depends on ppcrel_pkg, ppcrel_out_if and ppc_relocation_patch_core_assert.svh.
`include "ppc_relocation_patch_core_assert.svh"

module ppcrel_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  ppcrel_pkg::merge_t stage,
  output logic               ready,
  ppcrel_out_if.source       patch
);
  import ppcrel_pkg::*;

  logic [WordW-1:0] patch_next;
  logic             half_next;
  logic             bad_next;
  logic [HalfW-1:0] ha_hi;
  logic             out_valid;

  // high-adjusted: carry the rounding bit into the upper half
  assign ha_hi = stage.value[WordW-1:HalfW] + {{(HalfW-1){1'b0}}, stage.value[HalfW-1]};

  always_comb begin
    patch_next = '0;
    half_next  = 1'b0;
    bad_next   = 1'b0;
    case (stage.form)
      FORM_W32:  patch_next = stage.value;
      FORM_F24:  patch_next = (stage.old_word & F24_KEEP) | (stage.value & F24_INS);
      FORM_F14:  patch_next = (stage.old_word & F14_KEEP) | (stage.value & F14_INS);
      FORM_F14T: patch_next = (stage.old_word & F14H_KEEP) | (stage.value & F14_INS) | F14_HINT;
      FORM_F14N: patch_next = (stage.old_word & F14H_KEEP) | (stage.value & F14_INS);
      FORM_W30:  patch_next = (stage.old_word & W30_KEEP) | (stage.value & W30_INS);
      FORM_HALF: begin
        patch_next = {{(WordW-HalfW){1'b0}}, stage.value[HalfW-1:0]};
        half_next  = 1'b1;
      end
      FORM_HI: begin
        patch_next = {{(WordW-HalfW){1'b0}}, stage.value[WordW-1:HalfW]};
        half_next  = 1'b1;
      end
      FORM_HA: begin
        patch_next = {{(WordW-HalfW){1'b0}}, ha_hi};
        half_next  = 1'b1;
      end
      default:   bad_next = 1'b1;
    endcase
  end

  assign ready       = !out_valid || patch.ready;
  assign patch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      patch.target_address <= stage.target;
      patch.patch_value    <= patch_next;
      patch.halfword_write <= half_next;
      patch.unsupported    <= bad_next;
    end
  end

  `PPCREL_ASSERT(a_bad_no_write,
    patch.valid && patch.unsupported |-> patch.patch_value == '0 && !patch.halfword_write,
    "unsupported result carries write data")
  `PPCREL_ASSERT(a_half_upper_zero,
    patch.valid && patch.halfword_write |-> patch.patch_value[WordW-1:HalfW] == '0,
    "halfword patch has nonzero upper bits")
  `PPCREL_ASSERT(a_stall_blocks_stage,
    patch.valid && !patch.ready |-> !ready,
    "merge stage took a transfer while the output was held")
  `PPCREL_ASSERT_ALWAYS(a_reset_clears,
    $past(rst) |-> !patch.valid,
    "output valid set right after reset")

endmodule
